@@ src/complex_arithmetic_unit_defines.svh @@
// Assertion macros for the complex arithmetic unit checker.
// Used by cau_checker; no other dependencies.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// Clocked implication with reset disable.
`define CAU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a plain condition on every clock edge.
`define CAU_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

`endif

@@ src/cau_pkg.sv @@
// Shared constants and types for the complex arithmetic unit.
// No dependencies.
package cau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_REM = 3'd4;
    localparam logic [2:0] CMD_NEG = 3'd5;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    typedef struct packed {
        logic [2:0] cmd;
        logic       dz;
        logic       neg_re;
        logic       neg_im;
        logic       ovf_re;
        logic       ovf_im;
        logic       sat;
    } t_ctl;

endpackage

@@ src/cau_div_cell.sv @@
// One restoring-division step: shift in a numerator bit, compare, subtract.
// Depends on nothing; instantiated in a chain by complex_arithmetic_unit.
module cau_div_cell #(
    parameter int PW = 64,
    parameter int K  = 33
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [PW-1:0] i_r,
    input  logic [K-1:0]  i_n,
    input  logic [K-1:0]  i_q,
    input  logic [PW-1:0] i_den,
    output logic [PW-1:0] o_r,
    output logic [K-1:0]  o_n,
    output logic [K-1:0]  o_q,
    output logic [PW-1:0] o_den
);

    logic [PW:0] rs;
    logic [PW:0] diff;
    logic        ge;
    logic [PW-1:0] n_r;

    assign rs   = {i_r, i_n[K-1]};
    assign ge   = rs >= {1'b0, i_den};
    assign diff = rs - {1'b0, i_den};
    assign n_r  = ge ? diff[PW-1:0] : rs[PW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_r   <= n_r;
            o_n   <= {i_n[K-2:0], 1'b0};
            o_q   <= {i_q[K-2:0], ge};
            o_den <= i_den;
        end
    end

endmodule

@@ src/cau_front.sv @@
// Front stages: operand capture, products, sums, divider setup and simple results.
// Depends on cau_pkg.
module cau_front #(
    parameter int W = cau_pkg::DATA_WIDTH,
    parameter int F = cau_pkg::FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [2:0]          i_command,
    input  logic signed [W-1:0] i_a_re,
    input  logic signed [W-1:0] i_a_im,
    input  logic signed [W-1:0] i_b_re,
    input  logic signed [W-1:0] i_b_im,
    output logic [2*W-1:0]      o_r_re,
    output logic [W:0]          o_n_re,
    output logic [2*W-1:0]      o_den_re,
    output logic [2*W-1:0]      o_r_im,
    output logic [W:0]          o_n_im,
    output logic [2*W-1:0]      o_den_im,
    output logic [W-1:0]        o_pre_re,
    output logic [W-1:0]        o_pre_im,
    output cau_pkg::t_ctl       o_ctl
);

    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int K  = W + 1;
    localparam int NF = PW + F;
    localparam logic signed [SW-1:0] VMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] VMIN = ~VMAX;
    localparam logic signed [SW-1:0] BIAS = SW'((65'd1 << F) - 65'd1);

    // stage 1
    logic [2:0]          r_cmd1;
    logic signed [W-1:0] r_ar1, r_ai1, r_br1, r_bi1;
    // stage 2
    logic [2:0]           r_cmd2;
    logic signed [W-1:0]  r_ar2, r_ai2, r_br2, r_bi2;
    logic signed [PW-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_bb, r_p_cc;
    // stage 3
    logic [2:0]           r_cmd3;
    logic signed [W-1:0]  r_ar3, r_br3;
    logic signed [SW-1:0] r_mre, r_mim, r_dre, r_dim, r_sre, r_sim;
    logic [PW-1:0]        r_den3;

    logic signed [SW-1:0] n_sre, n_sim;
    logic signed [SW-1:0] tre, tim, vre, vim;
    logic [PW-1:0]        mag_re, mag_im;
    logic [NF-1:0]        nf_re, nf_im;
    logic [PW-1:0]        hi_re, hi_im;
    logic [W-1:0]         mag_a, mag_b, ia, ib;
    logic                 sat_re, sat_im;
    logic [PW-1:0]        n_r_re, n_den_re;
    logic [K-1:0]         n_n_re;
    cau_pkg::t_ctl        n_ctl;

    function automatic logic [W-1:0] sat_val(input logic signed [SW-1:0] v);
        if (v > VMAX) begin
            sat_val = VMAX[W-1:0];
        end else if (v < VMIN) begin
            sat_val = VMIN[W-1:0];
        end else begin
            sat_val = v[W-1:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cmd1 <= i_command;
            r_ar1  <= i_a_re;
            r_ai1  <= i_a_im;
            r_br1  <= i_b_re;
            r_bi1  <= i_b_im;

            r_cmd2 <= r_cmd1;
            r_ar2  <= r_ar1;
            r_ai2  <= r_ai1;
            r_br2  <= r_br1;
            r_bi2  <= r_bi1;
            r_p_rr <= PW'(r_ar1) * PW'(r_br1);
            r_p_ii <= PW'(r_ai1) * PW'(r_bi1);
            r_p_ri <= PW'(r_ar1) * PW'(r_bi1);
            r_p_ir <= PW'(r_ai1) * PW'(r_br1);
            r_p_bb <= PW'(r_br1) * PW'(r_br1);
            r_p_cc <= PW'(r_bi1) * PW'(r_bi1);

            r_cmd3 <= r_cmd2;
            r_ar3  <= r_ar2;
            r_br3  <= r_br2;
            r_mre  <= SW'(r_p_rr) - SW'(r_p_ii);
            r_mim  <= SW'(r_p_ri) + SW'(r_p_ir);
            r_dre  <= SW'(r_p_rr) + SW'(r_p_ii);
            r_dim  <= SW'(r_p_ir) - SW'(r_p_ri);
            r_den3 <= r_p_bb + r_p_cc;
            r_sre  <= n_sre;
            r_sim  <= n_sim;

            o_r_re   <= n_r_re;
            o_n_re   <= n_n_re;
            o_den_re <= n_den_re;
            o_r_im   <= hi_im;
            o_n_im   <= nf_im[K-1:0];
            o_den_im <= r_den3;
            o_pre_re <= sat_val(vre);
            o_pre_im <= sat_val(vim);
            o_ctl    <= n_ctl;
        end
    end

    always_comb begin
        case (r_cmd2)
            cau_pkg::CMD_ADD: begin
                n_sre = SW'(r_ar2) + SW'(r_br2);
                n_sim = SW'(r_ai2) + SW'(r_bi2);
            end
            cau_pkg::CMD_SUB: begin
                n_sre = SW'(r_ar2) - SW'(r_br2);
                n_sim = SW'(r_ai2) - SW'(r_bi2);
            end
            cau_pkg::CMD_NEG: begin
                n_sre = -SW'(r_ar2);
                n_sim = -SW'(r_ai2);
            end
            default: begin
                n_sre = '0;
                n_sim = '0;
            end
        endcase
    end

    always_comb begin
        tre = $signed(r_mre + (r_mre[SW-1] ? BIAS : '0)) >>> F;
        tim = $signed(r_mim + (r_mim[SW-1] ? BIAS : '0)) >>> F;
        vre = (r_cmd3 == cau_pkg::CMD_MUL) ? tre : r_sre;
        vim = (r_cmd3 == cau_pkg::CMD_MUL) ? tim : r_sim;
        sat_re = (vre > VMAX) || (vre < VMIN);
        sat_im = (vim > VMAX) || (vim < VMIN);

        mag_re = r_dre[SW-1] ? PW'(-r_dre) : PW'(r_dre);
        mag_im = r_dim[SW-1] ? PW'(-r_dim) : PW'(r_dim);
        nf_re  = NF'(mag_re) << F;
        nf_im  = NF'(mag_im) << F;
        hi_re  = PW'(nf_re >> K);
        hi_im  = PW'(nf_im >> K);

        mag_a = r_ar3[W-1] ? W'(-r_ar3) : W'(r_ar3);
        mag_b = r_br3[W-1] ? W'(-r_br3) : W'(r_br3);
        ia    = mag_a >> F;
        ib    = mag_b >> F;

        n_ctl     = '0;
        n_ctl.cmd = r_cmd3;
        n_ctl.sat = sat_re || sat_im;
        n_r_re    = hi_re;
        n_n_re    = nf_re[K-1:0];
        n_den_re  = r_den3;
        case (r_cmd3)
            cau_pkg::CMD_DIV: begin
                n_ctl.dz     = (r_den3 == '0);
                n_ctl.neg_re = r_dre[SW-1];
                n_ctl.neg_im = r_dim[SW-1];
                n_ctl.ovf_re = (hi_re >= r_den3);
                n_ctl.ovf_im = (hi_im >= r_den3);
            end
            cau_pkg::CMD_REM: begin
                n_ctl.dz     = (ib == '0);
                n_ctl.neg_re = r_ar3[W-1];
                n_r_re       = '0;
                n_n_re       = K'(ia);
                n_den_re     = PW'(ib);
            end
            default: ;
        endcase
    end

endmodule

@@ src/complex_arithmetic_unit.sv @@
// Channel   | valid    | ready    | payload
// input     | i_valid  | o_ready  | i_command, i_a_re, i_a_im, i_b_re, i_b_im
// output    | o_valid  | i_ready  | o_res_re, o_res_im, o_status
// One item per cycle while the output is not stalled.
// Most of the pipeline is the chain of DATA_WIDTH + 1 restoring-division cells.
// A held result stalls the whole pipeline; o_ready is high whenever the output
// register is empty or being taken. Reset clears all valid flags.
// Top level: depends on cau_pkg, cau_front, cau_div_cell.
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [2:0]                   i_command,
    input  logic signed [DATA_WIDTH-1:0] i_a_re,
    input  logic signed [DATA_WIDTH-1:0] i_a_im,
    input  logic signed [DATA_WIDTH-1:0] i_b_re,
    input  logic signed [DATA_WIDTH-1:0] i_b_im,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_res_re,
    output logic signed [DATA_WIDTH-1:0] o_res_im,
    output logic [1:0]                   o_status
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W;
    localparam int K  = W + 1;
    localparam int NV = 4 + K;
    localparam logic [K-1:0] QMAX = K'({(W-1){1'b1}});
    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = ~VMAX;

    logic          en;
    logic [NV-1:0] r_v;

    logic [PW-1:0] c_r_re [K+1];
    logic [K-1:0]  c_n_re [K+1];
    logic [K-1:0]  c_q_re [K+1];
    logic [PW-1:0] c_d_re [K+1];
    logic [PW-1:0] c_r_im [K+1];
    logic [K-1:0]  c_n_im [K+1];
    logic [K-1:0]  c_q_im [K+1];
    logic [PW-1:0] c_d_im [K+1];

    cau_pkg::t_ctl r_ctl  [K+1];
    logic [W-1:0]  r_pre_re [K+1];
    logic [W-1:0]  r_pre_im [K+1];

    cau_pkg::t_ctl ctl;
    logic [W-1:0]  n_re, n_im, rem_v;
    logic [1:0]    n_st;
    logic          s_re, s_im;

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            o_valid <= 1'b0;
        end else if (en) begin
            r_v     <= {r_v[NV-2:0], i_valid};
            o_valid <= r_v[NV-1];
        end
    end

    cau_front #(.W(W), .F(F)) u_front (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_command (i_command),
        .i_a_re    (i_a_re),
        .i_a_im    (i_a_im),
        .i_b_re    (i_b_re),
        .i_b_im    (i_b_im),
        .o_r_re    (c_r_re[0]),
        .o_n_re    (c_n_re[0]),
        .o_den_re  (c_d_re[0]),
        .o_r_im    (c_r_im[0]),
        .o_n_im    (c_n_im[0]),
        .o_den_im  (c_d_im[0]),
        .o_pre_re  (r_pre_re[0]),
        .o_pre_im  (r_pre_im[0]),
        .o_ctl     (r_ctl[0])
    );

    assign c_q_re[0] = '0;
    assign c_q_im[0] = '0;

    for (genvar g = 0; g < K; g++) begin : g_cell
        cau_div_cell #(.PW(PW), .K(K)) u_re (
            .i_clk (i_clk),
            .i_en  (en),
            .i_r   (c_r_re[g]),
            .i_n   (c_n_re[g]),
            .i_q   (c_q_re[g]),
            .i_den (c_d_re[g]),
            .o_r   (c_r_re[g+1]),
            .o_n   (c_n_re[g+1]),
            .o_q   (c_q_re[g+1]),
            .o_den (c_d_re[g+1])
        );
        cau_div_cell #(.PW(PW), .K(K)) u_im (
            .i_clk (i_clk),
            .i_en  (en),
            .i_r   (c_r_im[g]),
            .i_n   (c_n_im[g]),
            .i_q   (c_q_im[g]),
            .i_den (c_d_im[g]),
            .o_r   (c_r_im[g+1]),
            .o_n   (c_n_im[g+1]),
            .o_q   (c_q_im[g+1]),
            .o_den (c_d_im[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ctl[g+1]    <= r_ctl[g];
                r_pre_re[g+1] <= r_pre_re[g];
                r_pre_im[g+1] <= r_pre_im[g];
            end
        end
    end

    function automatic logic div_sat(input logic [K-1:0] q, input logic neg,
                                     input logic ovf);
        div_sat = ovf || (neg ? (q > QMAX + K'(1)) : (q > QMAX));
    endfunction

    function automatic logic [W-1:0] div_val(input logic [K-1:0] q, input logic neg,
                                             input logic ovf);
        if (div_sat(q, neg, ovf)) begin
            div_val = neg ? VMIN : VMAX;
        end else begin
            div_val = neg ? W'(-q) : W'(q);
        end
    endfunction

    always_comb begin
        ctl   = r_ctl[K];
        rem_v = W'(c_r_re[K]) << F;
        s_re  = 1'b0;
        s_im  = 1'b0;
        n_re  = r_pre_re[K];
        n_im  = r_pre_im[K];
        n_st  = ctl.sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        case (ctl.cmd)
            cau_pkg::CMD_DIV: begin
                s_re = div_sat(c_q_re[K], ctl.neg_re, ctl.ovf_re);
                s_im = div_sat(c_q_im[K], ctl.neg_im, ctl.ovf_im);
                n_re = div_val(c_q_re[K], ctl.neg_re, ctl.ovf_re);
                n_im = div_val(c_q_im[K], ctl.neg_im, ctl.ovf_im);
                n_st = (s_re || s_im) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
            cau_pkg::CMD_REM: begin
                n_re = ctl.neg_re ? -rem_v : rem_v;
                n_im = '0;
                n_st = cau_pkg::ST_OK;
            end
            default: ;
        endcase
        if (ctl.dz) begin
            n_re = VMAX;
            n_im = '0;
            n_st = cau_pkg::ST_DZ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_res_re <= n_re;
            o_res_im <= n_im;
            o_status <= n_st;
        end
    end

endmodule

@@ src/cau_checker.sv @@
// Port-level checker for complex_arithmetic_unit, bound to the top level.
// Depends on cau_pkg and complex_arithmetic_unit_defines.svh.
`include "complex_arithmetic_unit_defines.svh"

module cau_port_checker #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_ready,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [DATA_WIDTH-1:0] o_res_re,
    input logic [DATA_WIDTH-1:0] o_res_im,
    input logic [1:0]            o_status
);

    localparam logic [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    logic out_stall;
    logic dz_seen;
    logic dz_ok;

    assign out_stall = o_valid && !i_ready;
    assign dz_seen   = o_valid && (o_status == cau_pkg::ST_DZ);
    assign dz_ok     = (o_res_re == VMAX) && (o_res_im == '0);

    `CAU_ASSERT(a_hold_valid, out_stall |=> o_valid, "output item dropped")
    `CAU_ASSERT(a_hold_data, out_stall |=> $stable(o_res_re) && $stable(o_res_im), "item changed")
    `CAU_ALWAYS(a_ready_free, !o_valid -> o_ready, "input blocked with empty output")
    `CAU_ALWAYS(a_status_code, !o_valid || o_status != 2'd3, "unknown status code")
    `CAU_ALWAYS(a_dz_value, !dz_seen || dz_ok, "bad divide-by-zero result")

endmodule

bind complex_arithmetic_unit cau_port_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_ready  (o_ready),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_res_re (o_res_re),
    .o_res_im (o_res_im),
    .o_status (o_status)
);
